>>> sv/irr_pkg.sv
// Shared types and constants for the interrupt redirection router.
package irr_pkg;

    localparam int LEGACY_CNT   = 16;
    localparam int LEGACY_IDX_W = 4;
    localparam logic [7:0] REDIR_BASE_INDEX = 8'h10;

    typedef enum logic [1:0] {
        MODE_LOAD_CTRL     = 2'd0,
        MODE_LOAD_OVR      = 2'd1,
        MODE_ROUTE_GLOBAL  = 2'd2,
        MODE_ROUTE_LEGACY  = 2'd3
    } irr_mode_t;

    typedef enum logic [1:0] {
        RES_LOAD_DONE = 2'd0,
        RES_ROUTED    = 2'd1,
        RES_MISS      = 2'd2
    } irr_res_t;

    typedef struct packed {
        irr_mode_t    mode;
        logic [2:0]   slot;
        logic         slot_valid;
        logic [31:0]  global_irq;
        logic [8:0]   pin_count;
        logic [7:0]   legacy_irq;
        logic [15:0]  trigger_flags;
        logic [7:0]   vector;
        logic [7:0]   dest_id;
        logic         masked;
    } irr_in_t;

    typedef struct packed {
        irr_res_t     result_code;
        logic [2:0]   controller;
        logic [7:0]   pin;
        logic [7:0]   low_reg_index;
        logic [63:0]  redir_entry;
    } irr_out_t;

    // Beat handed from the override stage to the route stage.
    typedef struct packed {
        irr_mode_t    mode;
        logic [2:0]   slot;
        logic         slot_valid;
        logic [31:0]  num;        // number to route, or base on a controller load
        logic [8:0]   pins;
        logic         pol_low;
        logic         trig_level;
        logic [7:0]   vector;
        logic [7:0]   dest_id;
        logic         masked;
    } irr_stage_t;

endpackage

>>> sv/irr_ovr_stage.sv
// Legacy override table and number/flags resolution stage.
module irr_ovr_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_vld,
    input  irr_pkg::irr_in_t    in_item,
    output logic                out_vld,
    output irr_pkg::irr_stage_t out_stage
);
    import irr_pkg::*;

    logic                    ovr_present_reg [LEGACY_CNT];
    logic [31:0]             ovr_target_reg  [LEGACY_CNT];
    logic [3:0]              ovr_flags_reg   [LEGACY_CNT];

    logic                    vld_reg;
    irr_stage_t              stage_reg;
    irr_stage_t              stage_next;

    logic                    idx_ok;
    logic [LEGACY_IDX_W-1:0] idx;
    logic                    ovr_load;

    assign idx_ok   = (in_item.legacy_irq[7:LEGACY_IDX_W] == '0);
    assign idx      = in_item.legacy_irq[LEGACY_IDX_W-1:0];
    assign ovr_load = in_vld && (in_item.mode == MODE_LOAD_OVR) && idx_ok;

    always_comb
    begin
        stage_next            = '0;
        stage_next.mode       = in_item.mode;
        stage_next.slot       = in_item.slot;
        stage_next.slot_valid = in_item.slot_valid;
        stage_next.pins       = in_item.pin_count;
        stage_next.vector     = in_item.vector;
        stage_next.dest_id    = in_item.dest_id;
        stage_next.masked     = in_item.masked;
        case (in_item.mode)
            MODE_ROUTE_LEGACY:
            begin
                if (idx_ok && ovr_present_reg[idx])
                begin
                    stage_next.num        = ovr_target_reg[idx];
                    stage_next.pol_low    = (ovr_flags_reg[idx][1:0] == 2'b11);
                    stage_next.trig_level = (ovr_flags_reg[idx][3:2] == 2'b11);
                end
                else
                begin
                    stage_next.num        = {24'b0, in_item.legacy_irq};
                end
            end
            default:
            begin
                stage_next.num        = in_item.global_irq;
                stage_next.pol_low    = (in_item.trigger_flags[1:0] == 2'b11);
                stage_next.trig_level = (in_item.trigger_flags[3:2] == 2'b11);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            for (int i = 0; i < LEGACY_CNT; i++)
            begin
                ovr_present_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_reg <= in_vld;
            if (ovr_load)
            begin
                ovr_present_reg[idx] <= in_item.slot_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_vld)
        begin
            stage_reg <= stage_next;
        end
        if (ovr_load)
        begin
            ovr_target_reg[idx] <= in_item.global_irq;
            ovr_flags_reg[idx]  <= in_item.trigger_flags[3:0];
        end
    end

    assign out_vld   = vld_reg;
    assign out_stage = stage_reg;

endmodule

>>> sv/irr_route_stage.sv
// Controller table, parallel range match and result register.
module irr_route_stage #(
    parameter int NUM_CONTROLLERS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_vld,
    input  irr_pkg::irr_stage_t in_stage,
    output logic                done,
    output irr_pkg::irr_out_t   result
);
    import irr_pkg::*;

    localparam int IDX_W = (NUM_CONTROLLERS > 1) ? $clog2(NUM_CONTROLLERS) : 1;

    logic [31:0]          base_reg  [NUM_CONTROLLERS];
    logic [8:0]           pins_reg  [NUM_CONTROLLERS];
    logic                 valid_reg [NUM_CONTROLLERS];

    logic                 done_reg;
    irr_out_t             result_reg;
    irr_out_t             result_next;

    logic [NUM_CONTROLLERS-1:0] hit;
    logic                 found;
    logic [IDX_W-1:0]     sel;
    logic [31:0]          pin_full;
    logic                 ctrl_load;
    logic                 is_route;

    assign ctrl_load = in_vld && (in_stage.mode == MODE_LOAD_CTRL);
    assign is_route  = (in_stage.mode == MODE_ROUTE_GLOBAL) ||
                       (in_stage.mode == MODE_ROUTE_LEGACY);

    // 33-bit end compare so a range near the top never wraps
    always_comb
    begin
        for (int i = 0; i < NUM_CONTROLLERS; i++)
        begin
            hit[i] = valid_reg[i] && (in_stage.num >= base_reg[i]) &&
                     ({1'b0, in_stage.num} < ({1'b0, base_reg[i]} + {24'b0, pins_reg[i]}));
        end
    end

    // lowest matching slot wins
    always_comb
    begin
        found = 1'b0;
        sel   = '0;
        for (int i = NUM_CONTROLLERS - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                found = 1'b1;
                sel   = IDX_W'(i);
            end
        end
    end

    assign pin_full = in_stage.num - base_reg[sel];

    always_comb
    begin
        result_next = '0;
        if (!is_route)
        begin
            result_next.result_code = RES_LOAD_DONE;
        end
        else if (!found)
        begin
            result_next.result_code = RES_MISS;
        end
        else
        begin
            result_next.result_code   = RES_ROUTED;
            result_next.controller    = 3'(sel);
            result_next.pin           = pin_full[7:0];
            result_next.low_reg_index = REDIR_BASE_INDEX + {pin_full[6:0], 1'b0};
            result_next.redir_entry   = {in_stage.dest_id, 39'b0, in_stage.masked,
                                         in_stage.trig_level, 1'b0, in_stage.pol_low,
                                         5'b0, in_stage.vector};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            for (int i = 0; i < NUM_CONTROLLERS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            done_reg <= in_vld;
            for (int i = 0; i < NUM_CONTROLLERS; i++)
            begin
                if (ctrl_load && ({29'b0, in_stage.slot} == 32'(i)))
                begin
                    valid_reg[i] <= in_stage.slot_valid;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_vld)
        begin
            result_reg <= result_next;
        end
        for (int i = 0; i < NUM_CONTROLLERS; i++)
        begin
            if (ctrl_load && ({29'b0, in_stage.slot} == 32'(i)))
            begin
                base_reg[i] <= in_stage.num;
                pins_reg[i] <= in_stage.pins;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> sv/interrupt_redirection_router_top.sv
// Interrupt redirection router: top level with input register and two stages.
// A beat passes the input, override and result registers, then shows with done high.
// Throughput: one beat per cycle; busy is never raised, the three registers always advance.
// Table writes land in order, so a route sees every load accepted before it.
// The result is presented for exactly one cycle; the receiver cannot stall it.
// Reset clears all valid and present bits, so every controller and override starts empty.
module interrupt_redirection_router_top #(
    parameter int NUM_CONTROLLERS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  irr_pkg::irr_in_t  item,
    output logic              done,
    output irr_pkg::irr_out_t result
);
    import irr_pkg::*;

    logic       in_vld_reg;
    irr_in_t    in_reg;

    logic       mid_vld;
    irr_stage_t mid_stage;

    // input register: decouples the port from the override lookup
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            in_reg <= item;
        end
    end

    // stage 1: override table, resolves number and flags
    irr_ovr_stage u_ovr (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_vld    (in_vld_reg),
        .in_item   (in_reg),
        .out_vld   (mid_vld),
        .out_stage (mid_stage)
    );

    // stage 2: controller table, range match, entry build
    irr_route_stage #(
        .NUM_CONTROLLERS (NUM_CONTROLLERS)
    ) u_route (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (mid_vld),
        .in_stage (mid_stage),
        .done     (done),
        .result   (result)
    );

    assign busy = 1'b0;

endmodule
